// ----- rtl/core/ccwa_pkg.sv -----
// ----------------------------------------------------------------------------
// ccwa_pkg
// Shared widths, register map and constants of the time-of-day clock.
// ----------------------------------------------------------------------------
package ccwa_pkg;

	localparam int HourW   = 5;
	localparam int MinW    = 6;
	localparam int SecW    = 6;
	localparam int DurW    = 8;

	localparam logic [HourW-1:0] HourMax = 5'd23;
	localparam logic [MinW-1:0]  MinMax  = 6'd59;
	localparam logic [SecW-1:0]  SecMax  = 6'd59;
	localparam logic [SecW-1:0]  ShowSecA = 6'd10;
	localparam logic [SecW-1:0]  ShowSecB = 6'd30;
	localparam logic [SecW-1:0]  ShowSecC = 6'd50;

	localparam int BurnPeriod = 15;

	// operation codes (s_tuser)
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	// register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_ALARM_ENABLE     = 3'd0;
	localparam logic [2:0] REG_ALARM_HOUR       = 3'd1;
	localparam logic [2:0] REG_ALARM_MINUTE     = 3'd2;
	localparam logic [2:0] REG_ALARM_DURATION_S = 3'd3;
	localparam logic [2:0] REG_AUTO_SHOW_ENABLE = 3'd4;

	localparam logic [DurW-1:0] DurationReset = 8'd60;

	// bit m is set when nonzero minute count m is a multiple of the burn period
	function automatic logic [63:0] burn_mask_f();
		logic [63:0] m;
		m = '0;
		for (int i = 1; i < 64; i++) begin
			m[i] = ((i % BurnPeriod) == 0);
		end
		return m;
	endfunction

	localparam logic [63:0] BurnMask = burn_mask_f();

	typedef struct packed {
		logic            alarm_active;
		logic            auto_show_start;
		logic            burn_request;
		logic            hour_rollover;
		logic            new_minute;
		logic            new_second;
		logic [SecW-1:0] second_now;
		logic [MinW-1:0] minute_now;
		logic [HourW-1:0] hour_now;
	} result_t;

endpackage

// ----- rtl/core/clock_counter_with_alarm.sv -----
// ----------------------------------------------------------------------------
// clock_counter_with_alarm
// 24-hour time-of-day counter fed by half-second ticks, with alarm timer.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one word per tick or time load. s_tuser selects the kind
//   (0 half-second tick, 1 load). Every word gives exactly one result word on
//   the master stream: the time after the word plus the event pulses.
//   APB port holds the alarm time, enable, duration and auto-show enable;
//   write it only while the stream is idle.
// Timing: the input register loads at the accepting edge, the result register
//   when the word advances from it. Throughput: one word per cycle while m_tready
//   is high, set by the single combinational update between the two.
// Stall: while m_tready is low the result register holds; the input register
//   still takes one more word, then s_tready drops until the result moves.
// Reset: time, phase and alarm clear; alarm duration resets to 60 seconds,
//   other registers to 0. Both streams come up empty.
// ----------------------------------------------------------------------------
module clock_counter_with_alarm
	import ccwa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// slave stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // load_hour[4:0], load_minute[10:5], load_second[16:11],
	                              // alarm_edit_mode[17], zero[23:18]
	input  logic        s_tuser,  // operation
	// master stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // hour_now[4:0], minute_now[10:5], second_now[16:11],
	                              // new_second[17], new_minute[18], hour_rollover[19],
	                              // burn_request[20], auto_show_start[21],
	                              // alarm_active[22], zero[23]
	// APB
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// configuration
	logic             alarm_enable_q;
	logic [HourW-1:0] alarm_hour_q;
	logic [MinW-1:0]  alarm_minute_q;
	logic [DurW-1:0]  alarm_duration_q;
	logic             auto_show_enable_q;

	// clock state
	logic             half_phase_q;
	logic [SecW-1:0]  second_q;
	logic [MinW-1:0]  minute_q;
	logic [HourW-1:0] hour_q;
	logic             alarm_on_q;
	logic [DurW-1:0]  alarm_left_q;

	// input register
	logic             valid_s1;
	logic             op_s1;
	logic [HourW-1:0] ld_hour_s1;
	logic [MinW-1:0]  ld_min_s1;
	logic [SecW-1:0]  ld_sec_s1;
	logic             edit_s1;

	// result register
	logic             out_valid_q;
	result_t          out_q;

	logic             advance;
	logic             cfg_wr;
	logic [2:0]       cfg_idx;

	logic             phase_n;
	logic [HourW-1:0] hour_n;
	logic [MinW-1:0]  minute_n;
	logic [SecW-1:0]  second_n;
	logic             alarm_on_n;
	logic [DurW-1:0]  alarm_left_n;
	logic [SecW-1:0]  sec_inc;
	logic [MinW-1:0]  min_inc;
	logic [HourW-1:0] hour_inc;
	logic             fired;
	result_t          res;

	assign pready   = 1'b1;
	assign cfg_idx  = paddr[4:2];
	assign cfg_wr   = psel && penable && pwrite && pready;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q};

	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			REG_ALARM_ENABLE:     prdata[0] = alarm_enable_q;
			REG_ALARM_HOUR:       prdata[HourW-1:0] = alarm_hour_q;
			REG_ALARM_MINUTE:     prdata[MinW-1:0] = alarm_minute_q;
			REG_ALARM_DURATION_S: prdata[DurW-1:0] = alarm_duration_q;
			REG_AUTO_SHOW_ENABLE: prdata[0] = auto_show_enable_q;
			default:              prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_enable_q     <= 1'b0;
			alarm_hour_q       <= '0;
			alarm_minute_q     <= '0;
			alarm_duration_q   <= DurationReset;
			auto_show_enable_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_ALARM_ENABLE:     alarm_enable_q     <= pwdata[0];
				REG_ALARM_HOUR:       alarm_hour_q       <= pwdata[HourW-1:0];
				REG_ALARM_MINUTE:     alarm_minute_q     <= pwdata[MinW-1:0];
				REG_ALARM_DURATION_S: alarm_duration_q   <= pwdata[DurW-1:0];
				REG_AUTO_SHOW_ENABLE: auto_show_enable_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// next-state update for the word in the input register
	always_comb begin
		phase_n      = half_phase_q;
		hour_n       = hour_q;
		minute_n     = minute_q;
		second_n     = second_q;
		alarm_on_n   = alarm_on_q;
		alarm_left_n = alarm_left_q;
		sec_inc      = second_q + 1'b1;
		min_inc      = minute_q + 1'b1;
		hour_inc     = hour_q + 1'b1;
		fired        = 1'b0;
		res          = '0;

		if (op_s1 == OP_LOAD) begin
			hour_n   = (ld_hour_s1 > HourMax) ? HourMax : ld_hour_s1;
			minute_n = (ld_min_s1 > MinMax) ? MinMax : ld_min_s1;
			second_n = (ld_sec_s1 > SecMax) ? SecMax : ld_sec_s1;
		end else begin
			phase_n = ~half_phase_q;
			if (phase_n) begin
				res.new_second = 1'b1;
				second_n = sec_inc;
				if (sec_inc > SecMax) begin
					second_n         = '0;
					minute_n         = min_inc;
					res.new_minute   = 1'b1;
					res.burn_request = BurnMask[min_inc];
					if (min_inc > MinMax) begin
						minute_n          = '0;
						res.hour_rollover = 1'b1;
						hour_n            = (hour_inc > HourMax) ? '0 : hour_inc;
					end
				end
				res.auto_show_start = auto_show_enable_q &&
					(second_n == ShowSecA || second_n == ShowSecB || second_n == ShowSecC);
				if (res.new_minute && alarm_enable_q && !edit_s1 &&
					hour_n == alarm_hour_q && minute_n == alarm_minute_q) begin
					fired        = 1'b1;
					alarm_on_n   = 1'b1;
					alarm_left_n = (alarm_duration_q != '0) ? alarm_duration_q : DurW'(1);
				end
				if (!fired && alarm_on_q) begin
					if (alarm_left_q != '0) begin
						alarm_left_n = alarm_left_q - 1'b1;
					end
					if (alarm_left_n == '0) begin
						alarm_on_n = 1'b0;
					end
				end
			end
		end

		res.hour_now     = hour_n;
		res.minute_now   = minute_n;
		res.second_now   = second_n;
		res.alarm_active = alarm_on_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1      <= s_tuser;
			ld_hour_s1 <= s_tdata[4:0];
			ld_min_s1  <= s_tdata[10:5];
			ld_sec_s1  <= s_tdata[16:11];
			edit_s1    <= s_tdata[17];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_phase_q <= 1'b0;
			second_q     <= '0;
			minute_q     <= '0;
			hour_q       <= '0;
			alarm_on_q   <= 1'b0;
			alarm_left_q <= '0;
		end else if (advance) begin
			half_phase_q <= phase_n;
			second_q     <= second_n;
			minute_q     <= minute_n;
			hour_q       <= hour_n;
			alarm_on_q   <= alarm_on_n;
			alarm_left_q <= alarm_left_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

endmodule

// ----- test/tb_clock_counter_with_alarm.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_clock_counter_with_alarm
// Self-checking bench for the time-of-day clock with alarm. A scoreboard keeps
// its own copy of the clock state and registers, predicts the result word for
// every accepted input word, and compares each output word field by field.
// Directed words cover saturation, wraps, pulses and the alarm corners; random
// words with loads aimed at minute edges and the alarm time follow, with
// random idling on both streams and one long output hold-off.
// ----------------------------------------------------------------------------
import ccwa_pkg::*;

class tod_scoreboard;
	// clock state
	logic             half_q;
	logic [SecW-1:0]  sec_q;
	logic [MinW-1:0]  min_q;
	logic [HourW-1:0] hour_q;
	logic             alarm_q;
	logic [DurW-1:0]  left_q;
	// registers
	logic             alarm_en_r;
	logic [HourW-1:0] alarm_hour_r;
	logic [MinW-1:0]  alarm_min_r;
	logic [DurW-1:0]  duration_r;
	logic             show_en_r;

	result_t     expected_times[$];
	int unsigned errors;

	function new();
		half_q = 1'b0;
		sec_q = '0;
		min_q = '0;
		hour_q = '0;
		alarm_q = 1'b0;
		left_q = '0;
		alarm_en_r = 1'b0;
		alarm_hour_r = '0;
		alarm_min_r = '0;
		duration_r = DurationReset;
		show_en_r = 1'b0;
		errors = 0;
	endfunction

	function void set_reg(int idx, logic [31:0] value);
		case (idx)
			REG_ALARM_ENABLE:     alarm_en_r = value[0];
			REG_ALARM_HOUR:       alarm_hour_r = value[HourW-1:0];
			REG_ALARM_MINUTE:     alarm_min_r = value[MinW-1:0];
			REG_ALARM_DURATION_S: duration_r = value[DurW-1:0];
			REG_AUTO_SHOW_ENABLE: show_en_r = value[0];
			default: ;
		endcase
	endfunction

	function void advance_time(logic op, logic [HourW-1:0] lh, logic [MinW-1:0] lm,
			logic [SecW-1:0] ls, logic edit);
		result_t r;
		logic fired;
		r = '0;
		fired = 1'b0;
		if (op == OP_LOAD) begin
			hour_q = (lh > HourMax) ? HourMax : lh;
			min_q = (lm > MinMax) ? MinMax : lm;
			sec_q = (ls > SecMax) ? SecMax : ls;
		end else begin
			half_q = ~half_q;
			if (half_q) begin
				r.new_second = 1'b1;
				sec_q = sec_q + 6'd1;
				if (sec_q > SecMax) begin
					sec_q = '0;
					min_q = min_q + 6'd1;
					r.new_minute = 1'b1;
					// minute count here is 1..60, before the wrap
					if ((int'(min_q) % BurnPeriod) == 0)
						r.burn_request = 1'b1;
				end
				if (min_q > MinMax) begin
					min_q = '0;
					r.hour_rollover = 1'b1;
					hour_q = (hour_q >= HourMax) ? '0 : hour_q + 5'd1;
				end
				if (show_en_r && (sec_q == ShowSecA || sec_q == ShowSecB || sec_q == ShowSecC))
					r.auto_show_start = 1'b1;
				if (r.new_minute && alarm_en_r && !edit &&
						hour_q == alarm_hour_r && min_q == alarm_min_r) begin
					alarm_q = 1'b1;
					left_q = (duration_r == '0) ? 8'd1 : duration_r;
					fired = 1'b1;
				end
				if (!fired && alarm_q) begin
					if (left_q != '0)
						left_q = left_q - 8'd1;
					if (left_q == '0)
						alarm_q = 1'b0;
				end
			end
		end
		r.hour_now = hour_q;
		r.minute_now = min_q;
		r.second_now = sec_q;
		r.alarm_active = alarm_q;
		expected_times.push_back(r);
	endfunction

	function void check_field(string field, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			errors++;
		end
	endfunction

	function void check_time(logic [23:0] word);
		result_t want;
		result_t got;
		if (expected_times.size() == 0) begin
			$error("result word %h with no word expected", word);
			errors++;
			return;
		end
		want = expected_times.pop_front();
		got = result_t'(word[22:0]);
		check_field("hour_now", want.hour_now, got.hour_now);
		check_field("minute_now", want.minute_now, got.minute_now);
		check_field("second_now", want.second_now, got.second_now);
		check_field("new_second", want.new_second, got.new_second);
		check_field("new_minute", want.new_minute, got.new_minute);
		check_field("hour_rollover", want.hour_rollover, got.hour_rollover);
		check_field("burn_request", want.burn_request, got.burn_request);
		check_field("auto_show_start", want.auto_show_start, got.auto_show_start);
		check_field("alarm_active", want.alarm_active, got.alarm_active);
	endfunction
endclass

module tb_clock_counter_with_alarm;

	localparam int REG_SPARE_LO = 5;
	localparam int REG_SPARE_HI = 7;
	localparam int HoldCycles = 300;
	localparam int PhaseWords = 300;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;  // load_hour[4:0], load_minute[10:5], load_second[16:11],
	                       // alarm_edit_mode[17], zero[23:18]
	logic        s_tuser;  // operation
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;  // hour_now[4:0], minute_now[10:5], second_now[16:11],
	                       // new_second[17], new_minute[18], hour_rollover[19],
	                       // burn_request[20], auto_show_start[21], alarm_active[22]
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	tod_scoreboard    sb;
	logic             gaps_on;
	logic             final_part;
	logic             hold_req;
	int               tx_quiet;
	logic [HourW-1:0] cfg_hour;
	logic [MinW-1:0]  cfg_minute;

	clock_counter_with_alarm dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_time(m_tdata);
	end

	// output side: random stalls, one long hold-off, none at the end
	initial begin
		logic hold_done;
		hold_done = 1'b0;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (final_part) begin
				m_tready <= 1'b1;
			end else if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HoldCycles) @(negedge clk);
				m_tready <= 1'b1;
			end else if ($urandom_range(0, 39) == 0) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(20, 60)) @(negedge clk);
			end else if ($urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		#10_000_000;
		$display("tb_clock_counter_with_alarm: FAIL");
		$finish;
	end

	// all tasks start and end just after a falling edge
	task automatic write_reg(int idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'(idx * 4);
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		sb.set_reg(idx, value);
	endtask

	task automatic configure(logic en, logic [HourW-1:0] hr, logic [MinW-1:0] mn,
			logic [DurW-1:0] dur, logic show);
		write_reg(REG_ALARM_ENABLE, {31'b0, en});
		write_reg(REG_ALARM_HOUR, {27'b0, hr});
		write_reg(REG_ALARM_MINUTE, {26'b0, mn});
		write_reg(REG_ALARM_DURATION_S, {24'b0, dur});
		write_reg(REG_AUTO_SHOW_ENABLE, {31'b0, show});
		psel <= 1'b0;
		penable <= 1'b0;
		cfg_hour = hr;
		cfg_minute = mn;
		@(negedge clk);
	endtask

	task automatic push_word(logic op, logic [HourW-1:0] lh, logic [MinW-1:0] lm,
			logic [SecW-1:0] ls, logic edit);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {6'b0, edit, ls, lm, lh};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.advance_time(op, lh, lm, ls, edit);
		@(negedge clk);
		if (gaps_on) begin
			if (tx_quiet > 0) begin
				tx_quiet--;
			end else if ($urandom_range(0, 39) == 0) begin
				tx_quiet = $urandom_range(20, 60);
			end else if ($urandom_range(0, 4) == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end
		end
	endtask

	// mostly ticks; loads aim at minute edges and the alarm minute
	task automatic random_item();
		logic [HourW-1:0] lh;
		logic [MinW-1:0]  lm;
		logic [SecW-1:0]  ls;
		logic             edit;
		int               t;
		lh = 5'($urandom_range(0, 31));
		lm = 6'($urandom_range(0, 63));
		ls = 6'($urandom_range(0, 63));
		edit = ($urandom_range(0, 4) == 0);
		if ($urandom_range(0, 99) < 88) begin
			push_word(OP_TICK, lh, lm, ls, edit);
		end else begin
			case ($urandom_range(0, 3))
				0: ;
				1: begin
					t = (int'(cfg_hour) * 60 + int'(cfg_minute) + 1439) % 1440;
					lh = 5'(t / 60);
					lm = 6'(t % 60);
					ls = 6'($urandom_range(50, 59));
				end
				2: begin
					lh = 5'($urandom_range(0, 23));
					lm = ($urandom_range(0, 1) == 0) ? 6'd59 : 6'($urandom_range(0, 59));
					ls = 6'($urandom_range(55, 59));
				end
				default: begin
					lh = 5'($urandom_range(0, 23));
					lm = 6'($urandom_range(0, 59));
					ls = 6'($urandom_range(0, 59));
				end
			endcase
			push_word(OP_LOAD, lh, lm, ls, edit);
		end
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.expected_times.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_TICK;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		gaps_on = 1'b1;
		final_part = 1'b0;
		hold_req = 1'b0;
		tx_quiet = 0;
		cfg_hour = '0;
		cfg_minute = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// alarm at midnight with zero duration, show pulses on
		configure(1'b1, 5'd0, 6'd0, 8'd0, 1'b1);
		push_word(OP_LOAD, 5'd31, 6'd63, 6'd63, 1'b0);  // saturates to 23:59:59
		push_word(OP_TICK, 5'd0, 6'd0, 6'd0, 1'b0);     // day wrap, alarm fires
		push_word(OP_TICK, 5'd31, 6'd63, 6'd63, 1'b1);  // first half, fields ignored
		push_word(OP_TICK, 5'd0, 6'd0, 6'd0, 1'b0);     // one-second alarm ends
		push_word(OP_LOAD, 5'd0, 6'd0, 6'd9, 1'b1);
		push_word(OP_TICK, 5'd0, 6'd0, 6'd0, 1'b0);
		push_word(OP_TICK, 5'd0, 6'd0, 6'd0, 1'b0);     // show at 10
		push_word(OP_LOAD, 5'd12, 6'd14, 6'd59, 1'b0);
		push_word(OP_TICK, 5'd0, 6'd0, 6'd0, 1'b0);
		push_word(OP_TICK, 5'd0, 6'd0, 6'd0, 1'b0);     // minute 15, burn
		push_word(OP_LOAD, 5'd5, 6'd5, 6'd29, 1'b0);
		push_word(OP_TICK, 5'd0, 6'd0, 6'd0, 1'b0);
		push_word(OP_TICK, 5'd0, 6'd0, 6'd0, 1'b0);     // show at 30
		push_word(OP_LOAD, 5'd5, 6'd5, 6'd49, 1'b0);
		push_word(OP_TICK, 5'd0, 6'd0, 6'd0, 1'b0);
		push_word(OP_TICK, 5'd0, 6'd0, 6'd0, 1'b0);     // show at 50
		push_word(OP_LOAD, 5'd23, 6'd59, 6'd59, 1'b0);
		push_word(OP_TICK, 5'd0, 6'd0, 6'd0, 1'b1);
		push_word(OP_TICK, 5'd0, 6'd0, 6'd0, 1'b1);     // match blocked by edit mode
		settle();

		// long alarm, then a second match while it sounds
		write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
		write_reg(REG_SPARE_HI, 32'h0000_0001);
		configure(1'b1, 5'd0, 6'd0, 8'd255, 1'b0);
		push_word(OP_LOAD, 5'd23, 6'd59, 6'd59, 1'b0);
		push_word(OP_TICK, 5'd0, 6'd0, 6'd0, 1'b0);
		push_word(OP_TICK, 5'd0, 6'd0, 6'd0, 1'b0);
		push_word(OP_LOAD, 5'd23, 6'd59, 6'd59, 1'b0);
		push_word(OP_TICK, 5'd0, 6'd0, 6'd0, 1'b0);
		push_word(OP_TICK, 5'd0, 6'd0, 6'd0, 1'b0);     // countdown restarts
		settle();

		for (int p = 0; p < 5; p++) begin
			case (p)
				0: configure(1'b1, 5'd23, 6'd59, 8'd1, 1'b1);
				1: configure(1'b1, 5'd0, 6'd0, 8'd255, 1'b0);
				2: begin
					write_reg(REG_SPARE_LO, 32'h0000_0017);
					configure(1'b0, 5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)),
						8'($urandom_range(1, 255)), 1'b1);
				end
				3: configure(1'b1, 5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)),
					8'($urandom_range(1, 20)), 1'($urandom_range(0, 1)));
				default: begin
					configure(1'b1, 5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)),
						8'($urandom_range(1, 255)), 1'b1);
					gaps_on = 1'b0;
					final_part = 1'b1;
				end
			endcase
			if (p == 1)
				hold_req = 1'b1;
			repeat (PhaseWords) random_item();
			settle();
		end

		repeat (8) @(negedge clk);
		if (sb.errors == 0 && sb.expected_times.size() == 0)
			$display("tb_clock_counter_with_alarm: PASS");
		else
			$display("tb_clock_counter_with_alarm: FAIL");
		$finish;
	end

endmodule

// ----- clock_counter_with_alarm.f -----
rtl/core/ccwa_pkg.sv
rtl/core/clock_counter_with_alarm.sv
test/tb_clock_counter_with_alarm.sv
